// ===== hdl/srsm_pkg.sv =====
package srsm_pkg;

	localparam int SLOTS_DEF = 8;
	localparam int IDX_W     = 3;
	localparam int OP_W      = 3;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 3'd0,
		OP_ALLOC   = 3'd1,
		OP_RETURN  = 3'd2,
		OP_FINISH  = 3'd3,
		OP_RELEASE = 3'd4,
		OP_QUERY   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OPEN = 2'd0,
		ST_BUSY = 2'd1,
		ST_DONE = 2'd2
	} slot_st_t;

	typedef struct packed {
		logic             has_finished;
		logic             has_open;
		logic [IDX_W-1:0] finished_slot;
		logic [IDX_W-1:0] alloc_slot;
		logic             accepted;
	} result_t;

endpackage

// ===== hdl/srsm_engine.sv =====
module srsm_engine import srsm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  op_t              op,
	input  logic [IDX_W-1:0] idx,
	output result_t          res
);

	localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

	slot_st_t        slot_q   [SLOTS];
	slot_st_t        slot_nxt [SLOTS];
	logic [PW-1:0]   head_q, tail_q, head_nxt, tail_nxt;
	logic            acc;

	always_comb begin
		logic          idx_ok;
		logic [PW-1:0] ip;
		idx_ok   = 32'(idx) < SLOTS;
		ip       = PW'(idx);
		slot_nxt = slot_q;
		head_nxt = head_q;
		tail_nxt = tail_q;
		acc      = 1'b0;
		res.alloc_slot = '0;
		unique case (op)
			OP_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					slot_nxt[i] = ST_OPEN;
				head_nxt = '0;
				tail_nxt = '0;
				acc      = 1'b1;
			end
			OP_ALLOC: begin
				if (slot_q[head_q] == ST_OPEN) begin
					slot_nxt[head_q] = ST_BUSY;
					head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;
					acc      = 1'b1;
				end
			end
			OP_RETURN: begin
				if (idx_ok && slot_q[ip] == ST_BUSY) begin
					slot_nxt[ip] = ST_OPEN;
					head_nxt = (head_q == '0) ? LAST : head_q - 1'b1;
					acc      = 1'b1;
				end
			end
			OP_FINISH: begin
				if (idx_ok && slot_q[ip] == ST_BUSY) begin
					slot_nxt[ip] = ST_DONE;
					acc = 1'b1;
				end
			end
			OP_RELEASE: begin
				if (idx_ok && slot_q[ip] == ST_DONE) begin
					slot_nxt[ip] = ST_OPEN;
					tail_nxt = (tail_q == LAST) ? '0 : tail_q + 1'b1;
					acc      = 1'b1;
				end
			end
			default: ;
		endcase
		res.accepted      = acc;
		res.alloc_slot    = (op == OP_ALLOC && acc) ? IDX_W'(head_q) : IDX_W'(head_nxt);
		res.finished_slot = IDX_W'(tail_nxt);
		res.has_open      = slot_nxt[head_nxt] == ST_OPEN;
		res.has_finished  = slot_nxt[tail_nxt] == ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_q[i] <= ST_OPEN;
			head_q <= '0;
			tail_q <= '0;
		end else if (go) begin
			slot_q <= slot_nxt;
			head_q <= head_nxt;
			tail_q <= tail_nxt;
		end
	end

endmodule

// ===== hdl/slot_ring_status_manager_core.sv =====
// Slot ring status tracker: a ring of SLOTS slots, each open, in progress or
// finished, with a head pointer for allocation and a tail pointer for release.
// Requests enter on the s_ channel: s_tuser carries the operation (clear,
// allocate, return, finish, release, query), s_tdata the slot index.
// Each request gives exactly one result on the m_ channel: accepted flag,
// allocated or head slot, tail slot, head-open and tail-finished flags.
// A request passes one input register, then the slot table and pointers update
// while the result register loads. Throughput is one request per cycle while
// m_tready does not stall the result; the slot table, read and written in
// the same cycle, carries the dependence from one request to the next.
// Reset opens every slot, sets both pointers to zero and empties both
// registers. When m_tready is low the result holds, the input register holds
// behind it and s_tready drops once both are full; nothing is lost.
module slot_ring_status_manager_core import srsm_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [2:0] slot_index
	input  logic [2:0]  s_tuser,  // [2:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [0] accepted, [3:1] alloc_slot, [6:4] finished_slot,
	                              // [7] has_open, [8] has_finished
);

	logic             vld_s1, vld_s2;
	op_t              op_s1;
	logic [IDX_W-1:0] idx_s1;
	result_t          res, res_s2;
	logic             out_rdy, go;

	assign out_rdy  = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || out_rdy;
	assign go       = vld_s1 && out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready)
				vld_s1 <= s_tvalid;
			if (out_rdy)
				vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= op_t'(s_tuser);
			idx_s1 <= s_tdata[IDX_W-1:0];
		end
		if (go)
			res_s2 <= res;
	end

	srsm_engine #(.SLOTS(SLOTS)) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.op     (op_s1),
		.idx    (idx_s1),
		.res    (res)
	);

	assign m_tvalid = vld_s2;
	assign m_tdata  = {7'd0, res_s2};

endmodule

// ===== hdl/srsm_checker.sv =====
module srsm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	logic [10:0] unused_in;
	assign unused_in = {s_tdata, s_tuser};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_new_from_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result appeared without a request");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("request stalled without output stall");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:9] == 7'd0)
		else $error("result padding not zero");

endmodule

bind slot_ring_status_manager_core srsm_checker u_srsm_checker (.*);
